>>> src/swms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types, widths and the control store of the sliding window mode block.
// ----------------------------------------------------------------------------
package swms_pkg;

  localparam int VALUE_COUNT = 256;
  localparam int WINDOW_MAX  = 256;

  localparam int SMP_W = 8;
  localparam int CFG_W = 9;
  localparam int SUM_W = 32;
  localparam int VAL_W = $clog2(VALUE_COUNT);
  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int CNT_W = WIN_W;
  localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             start_of_array;
  } in_item_t;

  typedef struct packed {
    logic [SMP_W-1:0] window_mode;
    logic [SUM_W-1:0] mode_sum;
  } out_item_t;

  typedef enum logic [3:0] {
    S_WAIT     = 4'd0,
    S_WIN_RD   = 4'd1,
    S_DEC_RD   = 4'd2,
    S_DEC_WR   = 4'd3,
    S_INC_RD   = 4'd4,
    S_INC_WR   = 4'd5,
    S_CHECK    = 4'd6,
    S_SCAN     = 4'd7,
    S_SCAN_END = 4'd8,
    S_SUM      = 4'd9,
    S_EMIT     = 4'd10,
    S_BACK     = 4'd11
  } step_t;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NO_XFER,
    JC_NOT_FULL,
    JC_SCAN_MORE,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    logic   accept;
    logic   win_rd;
    logic   cnt_rd_old;
    logic   cnt_wr_dec;
    logic   win_wr;
    logic   cnt_rd_new;
    logic   cnt_wr_inc;
    logic   advance;
    logic   scan;
    logic   sum;
    logic   emit;
    jcond_t jc;
    step_t  tgt;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t cw;
    cw = '0;
    case (s)
      S_WAIT: begin
        cw.accept = 1'b1;
        cw.jc     = JC_NO_XFER;
        cw.tgt    = S_WAIT;
      end
      S_WIN_RD: begin
        cw.win_rd = 1'b1;
        cw.jc     = JC_NOT_FULL;
        cw.tgt    = S_INC_RD;
      end
      S_DEC_RD: begin
        cw.cnt_rd_old = 1'b1;
        cw.jc         = JC_NONE;
        cw.tgt        = S_WAIT;
      end
      S_DEC_WR: begin
        cw.cnt_wr_dec = 1'b1;
        cw.jc         = JC_NONE;
        cw.tgt        = S_WAIT;
      end
      S_INC_RD: begin
        cw.win_wr     = 1'b1;
        cw.cnt_rd_new = 1'b1;
        cw.jc         = JC_NONE;
        cw.tgt        = S_WAIT;
      end
      S_INC_WR: begin
        cw.cnt_wr_inc = 1'b1;
        cw.advance    = 1'b1;
        cw.jc         = JC_NONE;
        cw.tgt        = S_WAIT;
      end
      S_CHECK: begin
        cw.jc  = JC_NOT_FULL;
        cw.tgt = S_WAIT;
      end
      S_SCAN: begin
        cw.scan = 1'b1;
        cw.jc   = JC_SCAN_MORE;
        cw.tgt  = S_SCAN;
      end
      S_SCAN_END: begin
        cw.jc  = JC_NONE;
        cw.tgt = S_WAIT;
      end
      S_SUM: begin
        cw.sum = 1'b1;
        cw.jc  = JC_NONE;
        cw.tgt = S_WAIT;
      end
      S_EMIT: begin
        cw.emit = 1'b1;
        cw.jc   = JC_OUT_BUSY;
        cw.tgt  = S_EMIT;
      end
      S_BACK: begin
        cw.jc  = JC_ALWAYS;
        cw.tgt = S_WAIT;
      end
      default: begin
        cw.jc  = JC_ALWAYS;
        cw.tgt = S_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

>>> src/sliding_window_mode_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_mode_sum
// Sliding window mode over a sample stream with a saturating sum of the modes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_stall   swms_pkg::in_item_t
//  out_     output     out_valid/out_stall swms_pkg::out_item_t
//  cfg_     input      cfg_valid/cfg_ready window size, 9 bits
//
// An item that fills no window passes the window read, increment and check
// steps before the next input transfer. One that gives a result also scans
// all VALUE_COUNT histogram entries through one RAM read port, and the item
// that first fills the window skips the decrement steps.
// Reset clears control state and all histogram valid bits at once.
// A result waits in the output register while the next item is taken in; a
// second result waits in the emit step while out_stall is high, and a pending
// cfg_valid holds off input transfers.
// ----------------------------------------------------------------------------
module sliding_window_mode_sum (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire swms_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output swms_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [swms_pkg::CFG_W-1:0]          cfg_data
);

  swms_pkg::step_t       step_r, step_nxt;
  swms_pkg::ctrl_word_t  cw;

  logic [swms_pkg::CFG_W-1:0] win_size_r;
  logic [swms_pkg::WIN_W-1:0] w_eff;
  logic [swms_pkg::POS_W-1:0] pos_r;
  logic [swms_pkg::WIN_W-1:0] fill_r;
  logic [swms_pkg::SUM_W-1:0] sum_r;
  logic [swms_pkg::VAL_W-1:0] smp_r;
  logic [swms_pkg::VAL_W-1:0] old_r;
  logic [swms_pkg::VAL_W-1:0] scan_idx_r;
  logic [swms_pkg::VAL_W-1:0] cmp_idx_r;
  logic                       cmp_en_r;
  logic [swms_pkg::CNT_W-1:0] best_cnt_r;
  logic [swms_pkg::VAL_W-1:0] best_val_r;
  logic                       vld_r [swms_pkg::VALUE_COUNT];
  logic                       cnt_vld_r;
  logic                       out_valid_r;
  swms_pkg::out_item_t        out_data_r;

  logic                       in_fire;
  logic                       cfg_fire;
  logic                       out_free;
  logic                       not_full;
  logic                       jump;
  logic                       clr;
  logic [swms_pkg::VAL_W-1:0] smp_sat;
  logic [swms_pkg::WIN_W-1:0] pos_start;
  logic [swms_pkg::WIN_W-1:0] pos_inc;
  logic [swms_pkg::SUM_W:0]   sum_ext;

  logic                       cnt_we;
  logic [swms_pkg::VAL_W-1:0] cnt_waddr;
  logic [swms_pkg::CNT_W-1:0] cnt_wdata;
  logic [swms_pkg::VAL_W-1:0] cnt_raddr;
  logic [swms_pkg::CNT_W-1:0] cnt_rdata;
  logic [swms_pkg::CNT_W-1:0] cnt_eff;
  logic [swms_pkg::VAL_W-1:0] win_rdata;

  assign cw        = swms_pkg::ucode(step_r);
  assign in_stall  = (step_r != swms_pkg::S_WAIT) || cfg_valid;
  assign cfg_ready = (step_r == swms_pkg::S_WAIT);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (win_size_r == '0) begin
      w_eff = swms_pkg::WIN_W'(1);
    end else if (32'(win_size_r) > swms_pkg::WINDOW_MAX) begin
      w_eff = swms_pkg::WIN_W'(swms_pkg::WINDOW_MAX);
    end else begin
      w_eff = swms_pkg::WIN_W'(win_size_r);
    end
  end

  always_comb begin
    if (32'(in_data.sample) >= swms_pkg::VALUE_COUNT) begin
      smp_sat = swms_pkg::VAL_W'(swms_pkg::VALUE_COUNT - 1);
    end else begin
      smp_sat = swms_pkg::VAL_W'(in_data.sample);
    end
  end

  assign not_full  = fill_r < w_eff;
  assign pos_start = in_data.start_of_array ? '0 : swms_pkg::WIN_W'(pos_r);
  assign pos_inc   = swms_pkg::WIN_W'(pos_r) + swms_pkg::WIN_W'(1);
  assign sum_ext   = {1'b0, sum_r} + (swms_pkg::SUM_W + 1)'(best_val_r);
  assign clr       = cfg_fire || (cw.accept && in_fire && in_data.start_of_array);
  assign cnt_eff   = cnt_vld_r ? cnt_rdata : '0;

  always_comb begin
    case (cw.jc)
      swms_pkg::JC_NONE:      jump = 1'b0;
      swms_pkg::JC_ALWAYS:    jump = 1'b1;
      swms_pkg::JC_NO_XFER:   jump = !in_fire;
      swms_pkg::JC_NOT_FULL:  jump = not_full;
      swms_pkg::JC_SCAN_MORE: jump = scan_idx_r != swms_pkg::VAL_W'(swms_pkg::VALUE_COUNT - 1);
      swms_pkg::JC_OUT_BUSY:  jump = !out_free;
      default:                jump = 1'b0;
    endcase
    step_nxt = jump ? cw.tgt : swms_pkg::step_t'(step_r + 4'd1);
  end

  always_comb begin
    if (cw.cnt_rd_old) begin
      cnt_raddr = win_rdata;
    end else if (cw.cnt_rd_new) begin
      cnt_raddr = smp_r;
    end else begin
      cnt_raddr = scan_idx_r;
    end
    cnt_we    = 1'b0;
    cnt_waddr = smp_r;
    cnt_wdata = swms_pkg::CNT_W'(cnt_eff + swms_pkg::CNT_W'(1));
    if (cw.cnt_wr_dec) begin
      cnt_we    = cnt_eff != '0;
      cnt_waddr = old_r;
      cnt_wdata = swms_pkg::CNT_W'(cnt_eff - swms_pkg::CNT_W'(1));
    end else if (cw.cnt_wr_inc) begin
      cnt_we = 1'b1;
    end
  end

  swms_ram #(
    .WIDTH(swms_pkg::CNT_W),
    .DEPTH(swms_pkg::VALUE_COUNT)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  swms_ram #(
    .WIDTH(swms_pkg::VAL_W),
    .DEPTH(swms_pkg::WINDOW_MAX)
  ) u_win_ram (
    .clk  (clk),
    .we   (cw.win_wr),
    .waddr(pos_r),
    .wdata(smp_r),
    .raddr(pos_r),
    .rdata(win_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= swms_pkg::S_WAIT;
      win_size_r  <= swms_pkg::CFG_W'(3);
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      cmp_en_r    <= 1'b0;
      best_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < swms_pkg::VALUE_COUNT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      step_r   <= step_nxt;
      cmp_en_r <= cw.scan;
      if (cfg_fire) begin
        win_size_r <= cfg_data;
        pos_r      <= '0;
        fill_r     <= '0;
        sum_r      <= '0;
        best_cnt_r <= '0;
      end
      if (clr) begin
        for (int i = 0; i < swms_pkg::VALUE_COUNT; i++) begin
          vld_r[i] <= 1'b0;
        end
      end else if (cnt_we) begin
        vld_r[cnt_waddr] <= 1'b1;
      end
      if (cw.accept && in_fire) begin
        pos_r <= (pos_start >= w_eff) ? '0 : swms_pkg::POS_W'(pos_start);
        if (in_data.start_of_array) begin
          fill_r <= '0;
          sum_r  <= '0;
        end
      end
      if (cw.advance) begin
        pos_r      <= (pos_inc >= w_eff) ? '0 : swms_pkg::POS_W'(pos_inc);
        best_cnt_r <= '0;
        if (not_full) begin
          fill_r <= fill_r + swms_pkg::WIN_W'(1);
        end
      end
      if (cmp_en_r && (cnt_eff > best_cnt_r)) begin
        best_cnt_r <= cnt_eff;
      end
      if (cw.sum) begin
        sum_r <= sum_ext[swms_pkg::SUM_W] ? '1 : sum_ext[swms_pkg::SUM_W-1:0];
      end
      if (cw.emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_vld_r <= vld_r[cnt_raddr];
    cmp_idx_r <= scan_idx_r;
    if (cw.accept && in_fire) begin
      smp_r <= smp_sat;
    end
    if (cw.cnt_rd_old) begin
      old_r <= win_rdata;
    end
    if (cw.advance) begin
      scan_idx_r <= '0;
      best_val_r <= '0;
    end else if (cw.scan) begin
      scan_idx_r <= scan_idx_r + swms_pkg::VAL_W'(1);
    end
    if (cmp_en_r && (cnt_eff > best_cnt_r)) begin
      best_val_r <= cmp_idx_r;
    end
    if (cw.emit && out_free) begin
      out_data_r.window_mode <= swms_pkg::SMP_W'(best_val_r);
      out_data_r.mode_sum    <= sum_r;
    end
  end

  a_emit_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r == swms_pkg::S_EMIT))
    else $error("result transfer started outside the emit step");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count beyond window size");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    swms_pkg::WIN_W'(pos_r) < w_eff)
    else $error("write position beyond window size");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_cnt_r <= w_eff)
    else $error("mode count beyond window size");

endmodule
`default_nettype wire

>>> src/swms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swms_ram
// Generic memory with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module swms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window mode and mode sum block.
// ----------------------------------------------------------------------------
// A behavioral copy of the window histogram predicts each result as samples
// are transferred in. The checker compares every result transfer with the
// oldest prediction. Directed tests cover the reset window size, value
// extremes, ties, array restarts and the window size limits. A random part
// then sends arrays under several idle and stall mixes, and a long output
// hold fills the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TAIL_CYCLES  = swms_pkg::VALUE_COUNT + 16;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  swms_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  swms_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [swms_pkg::CFG_W-1:0]     cfg_data = '0;

  int                             idle_pct = 0;
  int                             stall_pct = 0;
  logic                           hold_req = 1'b0;
  int                             hold_left = 0;
  int                             cycle_count = 0;
  int                             fail_count = 0;
  int                             items_in = 0;
  int                             results_seen = 0;
  int                             cfg_writes = 0;

  swms_pkg::out_item_t            pending_results[$];

  logic [swms_pkg::CFG_W-1:0]     win_cfg = swms_pkg::CFG_W'(3);
  logic [swms_pkg::CNT_W-1:0]     hist_count[swms_pkg::VALUE_COUNT];
  logic [swms_pkg::SMP_W-1:0]     delay_line[swms_pkg::WINDOW_MAX];
  int unsigned                    head_pos = 0;
  int unsigned                    filled = 0;
  logic [swms_pkg::SUM_W-1:0]     mode_total = '0;

  sliding_window_mode_sum i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $error("Timeout after %0d cycles.", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < stall_pct);
      if (hold_req) begin
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  always @(posedge clk) begin : check_results
    swms_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("Unexpected result: window_mode %0d mode_sum %0d",
               out_data.window_mode, out_data.mode_sum);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_data.window_mode !== want.window_mode) begin
          $error("window_mode: expected %0d, actual %0d", want.window_mode,
                 out_data.window_mode);
          fail_count++;
        end
        if (out_data.mode_sum !== want.mode_sum) begin
          $error("mode_sum: expected %0d, actual %0d", want.mode_sum, out_data.mode_sum);
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned eff_window();
    if (win_cfg == 0) begin
      return 1;
    end
    if (win_cfg > swms_pkg::WINDOW_MAX) begin
      return swms_pkg::WINDOW_MAX;
    end
    return 32'(win_cfg);
  endfunction

  function automatic void clear_hist();
    for (int v = 0; v < swms_pkg::VALUE_COUNT; v++) begin
      hist_count[v] = '0;
    end
    head_pos   = 0;
    filled     = 0;
    mode_total = '0;
  endfunction

  function automatic bit predict_mode_step(input swms_pkg::in_item_t it,
                                           output swms_pkg::out_item_t res);
    int unsigned                w;
    int unsigned                pos;
    logic [swms_pkg::SMP_W-1:0] old;
    logic [swms_pkg::SMP_W-1:0] best_val;
    logic [swms_pkg::CNT_W-1:0] best_cnt;
    logic [swms_pkg::SUM_W:0]   total;
    w   = eff_window();
    res = '0;
    if (it.start_of_array) begin
      clear_hist();
    end
    pos = head_pos;
    if (pos >= w) begin
      pos = 0;
    end
    if (filled >= w) begin
      old = delay_line[pos];
      if (hist_count[old] != 0) begin
        hist_count[old] = hist_count[old] - swms_pkg::CNT_W'(1);
      end
    end
    delay_line[pos] = it.sample;
    hist_count[it.sample] = hist_count[it.sample] + swms_pkg::CNT_W'(1);
    pos++;
    if (pos >= w) begin
      pos = 0;
    end
    head_pos = pos;
    if (filled < w) begin
      filled++;
    end
    if (filled < w) begin
      return 1'b0;
    end
    best_val = '0;
    best_cnt = '0;
    for (int v = 0; v < swms_pkg::VALUE_COUNT; v++) begin
      if (hist_count[v] > best_cnt) begin
        best_cnt = hist_count[v];
        best_val = v[swms_pkg::SMP_W-1:0];
      end
    end
    total = {1'b0, mode_total} + (swms_pkg::SUM_W + 1)'(best_val);
    mode_total = total[swms_pkg::SUM_W] ? '1 : total[swms_pkg::SUM_W-1:0];
    res.window_mode = best_val;
    res.mode_sum    = mode_total;
    return 1'b1;
  endfunction

  task automatic send_sample(input logic [swms_pkg::SMP_W-1:0] smp, input bit start);
    swms_pkg::in_item_t  it;
    swms_pkg::out_item_t res;
    it.sample         = smp;
    it.start_of_array = start;
    while (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_in++;
    if (predict_mode_step(it, res)) begin
      pending_results = {pending_results, res};
    end
  endtask

  // The block may still be working on an item that gives no result once the
  // queue runs empty, so a full item time passes before the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [swms_pkg::CFG_W-1:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_cfg = w;
    clear_hist();
    cfg_writes++;
  endtask

  function automatic logic [swms_pkg::SMP_W-1:0] pick_sample(
      input logic [swms_pkg::SMP_W-1:0] base);
    if ($urandom_range(3) == 0) begin
      return swms_pkg::SMP_W'($urandom_range(255));
    end
    return base + swms_pkg::SMP_W'($urandom_range(3));
  endfunction

  // The reset window size of three is used without any register write.
  task automatic test_reset_window();
    send_sample(8'd0, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd7, 1'b1);
    send_sample(8'd3, 1'b0);
    send_sample(8'd9, 1'b0);
    send_sample(8'd9, 1'b0);
    send_sample(8'd200, 1'b0);
    send_sample(8'd128, 1'b1);
    send_sample(8'd1, 1'b0);
    send_sample(8'd1, 1'b0);
    drain_results();
  endtask

  // A register write restarts the array even when the size does not change.
  task automatic test_config_restart();
    write_window(9'd3);
    send_sample(8'd5, 1'b1);
    send_sample(8'd5, 1'b0);
    drain_results();
    write_window(9'd3);
    send_sample(8'd6, 1'b0);
    send_sample(8'd6, 1'b0);
    send_sample(8'd6, 1'b0);
    drain_results();
  endtask

  task automatic test_window_limits();
    write_window(9'd0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd170, 1'b0);
    send_sample(8'd85, 1'b1);
    drain_results();
    write_window(9'd511);
    for (int k = 0; k < swms_pkg::WINDOW_MAX + 3; k++) begin
      send_sample(swms_pkg::SMP_W'($urandom_range(15)), k == 0);
    end
    drain_results();
  endtask

  task automatic test_random_arrays();
    int                         idle_mix[4];
    int                         stall_mix[4];
    int                         sent;
    int                         len;
    int                         pick;
    logic [swms_pkg::SMP_W-1:0] base;
    idle_mix  = '{0, 58, 0, 38};
    stall_mix = '{0, 0, 58, 38};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      sent = 0;
      while (sent < 80) begin
        if ($urandom_range(2) == 0) begin
          drain_results();
          pick = int'($urandom_range(9));
          if (pick < 6) begin
            write_window(swms_pkg::CFG_W'($urandom_range(1, 6)));
          end else if (pick < 9) begin
            write_window(swms_pkg::CFG_W'($urandom_range(7, 24)));
          end else begin
            write_window(swms_pkg::CFG_W'($urandom_range(0, 60)));
          end
        end
        len  = int'($urandom_range(1, 2 * eff_window() + 8));
        base = swms_pkg::SMP_W'($urandom_range(255));
        for (int k = 0; k < len; k++) begin
          send_sample(pick_sample(base), (k == 0) || ($urandom_range(19) == 0));
        end
        sent += len;
      end
    end
    drain_results();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // The output is held off for a long stretch while samples keep coming, so
  // the block fills up and stalls its input.
  task automatic test_output_hold();
    write_window(9'd2);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 30; k++) begin
      send_sample(swms_pkg::SMP_W'($urandom_range(255)), k == 0);
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    clear_hist();
    @(posedge clk);
    test_reset_window();
    test_config_restart();
    test_window_limits();
    test_random_arrays();
    test_output_hold();
    drain_results();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived.", pending_results.size());
      fail_count++;
    end
    $display("Run covered %0d sample transfers, %0d result transfers and %0d size writes.",
             items_in, results_seen, cfg_writes);
    $display("Window sizes 1 to 256, restarts, ties, idle mixes and a long hold were used.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/swms_pkg.sv
src/swms_ram.sv
src/sliding_window_mode_sum.sv
dv/tb.sv
